// ----- hw/rtl/gec_pkg.sv -----
// Shared types for the greedy edge color assigner.
// No dependencies; used by greedy_edge_color_assigner_core.
`default_nettype none

package gec_pkg;

    // Sequencer states of the core
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COUNT,
        ST_WRITE_B
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/greedy_edge_color_assigner_core.sv -----
// Greedy edge color assigner: top level with point mask and color count memories.
// Depends on gec_pkg (sequencer state type).
`default_nettype none

// Usage
// - Input channel (s_valid/s_ready): one word per edge, carrying the two endpoint
//   indices and a last_edge marker that closes a batch.
// - Result channel (m_valid/m_ready): one word per edge with the assigned color,
//   the edge's rank inside that color, and a flag when no color is free.
// - Each edge passes through ST_IDLE, ST_READ and ST_COUNT, and also ST_WRITE_B
//   when a color is found for two distinct endpoints: the point mask memory has
//   a single write port, so the two endpoint masks go back in separate cycles
//   after the mask read and the count read.
// - An accepted edge's result is registered for output after ST_READ and ST_COUNT.
// - A new edge is accepted while the previous result still waits in the output
//   register; a stalled receiver only stops the core when a new result is ready.
// - Reset and every last_edge start a clearing pass that zeroes both memories,
//   one entry per cycle, until every row of both is cleared; no edge is accepted
//   meanwhile.
// - Out-of-range endpoints and edges with no free color are flagged and leave
//   the memories untouched.
module greedy_edge_color_assigner_core #(
    parameter int POINT_COUNT_MAX = 4096,
    parameter int COLOR_COUNT_MAX = 32,
    parameter int EDGE_COUNT_MAX  = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [11:0] s_start_point,
    input  wire logic [11:0] s_end_point,
    input  wire logic        s_last_edge,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_edge_color,
    output logic [15:0]      m_rank_in_color,
    output logic             m_no_free_color
);

    // Only 12-bit indices can arrive, so the mask memory never needs more rows
    localparam int PT_DEPTH   = (POINT_COUNT_MAX < 4096) ? POINT_COUNT_MAX : 4096;
    localparam int PA_W       = $clog2(PT_DEPTH);
    localparam int CW         = $clog2(COLOR_COUNT_MAX);
    localparam int SW_LEN     = (PT_DEPTH > COLOR_COUNT_MAX) ? PT_DEPTH : COLOR_COUNT_MAX;
    localparam int SCW        = $clog2(SW_LEN);
    localparam int RANK_LIMIT = ((EDGE_COUNT_MAX - 1) < 65535) ? (EDGE_COUNT_MAX - 1) : 65535;

    // Memories: one used-color mask per point, one member count per color
    logic [COLOR_COUNT_MAX-1:0] pt_mem [PT_DEPTH];
    logic [15:0]                cnt_mem [COLOR_COUNT_MAX];

    gec_pkg::state_t state_reg, state_next;

    logic [SCW-1:0]  clr_reg, clr_next;
    logic [PA_W-1:0] a_reg, a_next;
    logic [PA_W-1:0] b_reg, b_next;
    logic            last_reg, last_next;
    logic            range_reg, range_next;
    logic            same_reg, same_next;

    logic [CW-1:0]              color_reg, color_next;
    logic                       found_reg, found_next;
    logic [COLOR_COUNT_MAX-1:0] new_a_reg, new_a_next;
    logic [COLOR_COUNT_MAX-1:0] new_b_reg, new_b_next;

    logic        m_valid_reg, m_valid_next;
    logic [4:0]  color_out_reg, color_out_next;
    logic [15:0] rank_out_reg, rank_out_next;
    logic        flag_out_reg, flag_out_next;

    // Memory read data (registered)
    logic [COLOR_COUNT_MAX-1:0] rd_a_reg, rd_b_reg;
    logic [15:0]                rd_cnt_reg;

    // Write port controls
    logic                       pt_we;
    logic [PA_W-1:0]            pt_waddr;
    logic [COLOR_COUNT_MAX-1:0] pt_wdata;
    logic                       cnt_we;
    logic [CW-1:0]              cnt_waddr;
    logic [15:0]                cnt_wdata;
    logic [CW-1:0]              cnt_raddr;

    // Lowest free color search
    logic [COLOR_COUNT_MAX-1:0] used;
    logic [COLOR_COUNT_MAX-1:0] color_bit;
    logic [CW-1:0]              ffz_color;
    logic                       ffz_found;
    logic [5:0]                 color_wide;
    logic                       out_free;
    logic                       in_take;

    assign in_take  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign used     = rd_a_reg | rd_b_reg;

    always_comb begin
        ffz_found = 1'b0;
        ffz_color = '0;
        for (int i = COLOR_COUNT_MAX - 1; i >= 0; i--) begin
            if (!used[i]) begin
                ffz_found = 1'b1;
                ffz_color = CW'(i);
            end
        end
        color_bit = '0;
        color_bit[ffz_color] = 1'b1;
    end

    // Hold the count read on the chosen color while the result waits
    assign cnt_raddr  = (state_reg == gec_pkg::ST_READ) ? ffz_color : color_reg;
    assign color_wide = 6'(color_reg);

    // Memory ports
    always_ff @(posedge aclk) begin
        rd_a_reg <= pt_mem[s_start_point[PA_W-1:0]];
        rd_b_reg <= pt_mem[s_end_point[PA_W-1:0]];
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_cnt_reg <= cnt_mem[cnt_raddr];
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gec_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        last_reg      <= last_next;
        range_reg     <= range_next;
        same_reg      <= same_next;
        color_reg     <= color_next;
        found_reg     <= found_next;
        new_a_reg     <= new_a_next;
        new_b_reg     <= new_b_next;
        color_out_reg <= color_out_next;
        rank_out_reg  <= rank_out_next;
        flag_out_reg  <= flag_out_next;
    end

    // Sequencer: next state, memory writes and result register loading
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        last_next      = last_reg;
        range_next     = range_reg;
        same_next      = same_reg;
        color_next     = color_reg;
        found_next     = found_reg;
        new_a_next     = new_a_reg;
        new_b_next     = new_b_reg;
        m_valid_next   = m_valid_reg;
        color_out_next = color_out_reg;
        rank_out_next  = rank_out_reg;
        flag_out_next  = flag_out_reg;
        pt_we          = 1'b0;
        pt_waddr       = a_reg;
        pt_wdata       = new_a_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = color_reg;
        cnt_wdata      = '0;
        s_ready        = 1'b0;

        // Drop the result word once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            gec_pkg::ST_CLEAR: begin
                // Zero one row of each memory per cycle
                if (32'(clr_reg) < PT_DEPTH) begin
                    pt_we    = 1'b1;
                    pt_waddr = clr_reg[PA_W-1:0];
                    pt_wdata = '0;
                end
                if (32'(clr_reg) < COLOR_COUNT_MAX) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = clr_reg[CW-1:0];
                    cnt_wdata = '0;
                end
                if (32'(clr_reg) == SW_LEN - 1) begin
                    clr_next   = '0;
                    state_next = gec_pkg::ST_IDLE;
                end else begin
                    clr_next = clr_reg + SCW'(1);
                end
            end
            gec_pkg::ST_IDLE: begin
                // Mask reads of both endpoints are issued straight from the ports
                s_ready = 1'b1;
                if (in_take) begin
                    a_next     = s_start_point[PA_W-1:0];
                    b_next     = s_end_point[PA_W-1:0];
                    last_next  = s_last_edge;
                    range_next = (17'(s_start_point) < 17'(POINT_COUNT_MAX)) &&
                                 (17'(s_end_point) < 17'(POINT_COUNT_MAX));
                    same_next  = (s_start_point == s_end_point);
                    state_next = gec_pkg::ST_READ;
                end
            end
            gec_pkg::ST_READ: begin
                // Masks are here: pick the lowest free color, read its count
                color_next = ffz_color;
                found_next = ffz_found && range_reg;
                new_a_next = rd_a_reg | color_bit;
                new_b_next = rd_b_reg | color_bit;
                state_next = gec_pkg::ST_COUNT;
            end
            gec_pkg::ST_COUNT: begin
                // Hold until the output register can take the result
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (found_reg) begin
                        color_out_next = color_wide[4:0];
                        rank_out_next  = rd_cnt_reg;
                        flag_out_next  = 1'b0;
                        pt_we          = 1'b1;
                        pt_waddr       = a_reg;
                        pt_wdata       = new_a_reg;
                        cnt_we         = 1'b1;
                        cnt_waddr      = color_reg;
                        cnt_wdata      = (rd_cnt_reg < 16'(RANK_LIMIT)) ?
                                         rd_cnt_reg + 16'd1 : rd_cnt_reg;
                    end else begin
                        color_out_next = '0;
                        rank_out_next  = '0;
                        flag_out_next  = 1'b1;
                    end
                    if (found_reg && !same_reg) begin
                        state_next = gec_pkg::ST_WRITE_B;
                    end else if (last_reg) begin
                        state_next = gec_pkg::ST_CLEAR;
                    end else begin
                        state_next = gec_pkg::ST_IDLE;
                    end
                end
            end
            gec_pkg::ST_WRITE_B: begin
                // Second endpoint mask goes back on the single write port
                pt_we      = 1'b1;
                pt_waddr   = b_reg;
                pt_wdata   = new_b_reg;
                state_next = last_reg ? gec_pkg::ST_CLEAR : gec_pkg::ST_IDLE;
            end
            default: begin
                state_next = gec_pkg::ST_CLEAR;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_edge_color    = color_out_reg;
    assign m_rank_in_color = rank_out_reg;
    assign m_no_free_color = flag_out_reg;

endmodule

`default_nettype wire

// ----- tb/greedy_edge_color_assigner_core_tb.sv -----
// Self-checking bench for greedy_edge_color_assigner_core: edge words in, color words out.
// Depends only on the core RTL; keeps its own model of point masks and color counts.
`default_nettype none

module greedy_edge_color_assigner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINTS         = 4096;
    localparam int COLORS         = 32;
    localparam int EDGE_MAX       = 65536;
    localparam int RANK_CAP       = (EDGE_MAX - 1 < 65535) ? EDGE_MAX - 1 : 65535;
    localparam int ITEMS_PER_MIX  = 175;
    localparam int STALL_LIMIT    = 20000;
    localparam int REPORT_MAX     = 10;
    localparam int TAIL_CYCLES    = 16;

    typedef struct packed {
        logic [11:0] start_pt;
        logic [11:0] end_pt;
        logic        last;
    } edge_word_t;

    typedef struct packed {
        logic [4:0]  color;
        logic [15:0] rank;
        logic        no_free;
    } color_result_t;

    // Clock, reset and block ports
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [11:0] s_start_point = '0;
    logic [11:0] s_end_point = '0;
    logic        s_last_edge = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_edge_color;
    logic [15:0] m_rank_in_color;
    logic        m_no_free_color;

    // Model state: one used-color mask per point, one member count per color
    logic [31:0] point_mask [POINTS];
    logic [15:0] color_count [COLORS];

    edge_word_t    edge_pending_q [$];
    color_result_t color_expect_q [$];

    int words_offered = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int flagged_seen = 0;
    int batches_closed = 0;
    int failures = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #10 aclk = ~aclk;

    greedy_edge_color_assigner_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_point   (s_start_point),
        .s_end_point     (s_end_point),
        .s_last_edge     (s_last_edge),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_edge_color    (m_edge_color),
        .m_rank_in_color (m_rank_in_color),
        .m_no_free_color (m_no_free_color)
    );

    function automatic void clear_color_state();
        foreach (point_mask[i]) point_mask[i] = '0;
        foreach (color_count[i]) color_count[i] = '0;
    endfunction

    // Greedy pick: lowest color free at both endpoints, then mark it at both
    // and hand out the current member count as the rank.
    function automatic color_result_t assign_color(input edge_word_t w);
        color_result_t r;
        logic [31:0]   used;
        int            c;
        r = '0;
        r.no_free = 1'b1;
        if (int'(w.start_pt) < POINTS && int'(w.end_pt) < POINTS) begin
            used = point_mask[w.start_pt] | point_mask[w.end_pt];
            c = 0;
            while (c < COLORS && used[c]) c++;
            if (c < COLORS) begin
                point_mask[w.start_pt][c] = 1'b1;
                point_mask[w.end_pt][c] = 1'b1;
                r.rank = color_count[c];
                if (int'(color_count[c]) < RANK_CAP) color_count[c] = color_count[c] + 16'd1;
                r.color = 5'(c);
                r.no_free = 1'b0;
            end
        end
        // Close the batch: both stores go back to zero after the result
        if (w.last) clear_color_state();
        return r;
    endfunction

    task automatic push_edge(input logic [11:0] a, input logic [11:0] b, input logic last);
        edge_word_t w;
        w.start_pt = a;
        w.end_pt = b;
        w.last = last;
        edge_pending_q.insert(edge_pending_q.size(), w);
    endtask

    task automatic note_failure(input string msg);
        if (failures < REPORT_MAX) $display("[%0t] FAIL: %s", $realtime, msg);
        failures++;
    endtask

    // Random stimulus built from short sequences:
    // - hub bursts push one point past all colors so the no-free case shows up
    // - dense pools of eight points interleave masks across many edges
    // - plain noise edges sweep every index bit
    // A batch closes now and then at the end of a sequence, and rarely in the middle.
    task automatic queue_random_edges(input int count);
        int          n;
        int          kind;
        int          len;
        logic [11:0] hub;
        logic [11:0] mate;
        logic [11:0] base;
        logic        cut;
        n = 0;
        while (n < count) begin
            kind = $urandom_range(9);
            if (kind <= 3) begin
                hub = 12'($urandom);
                len = $urandom_range(40, 30);
                for (int k = 0; k < len; k++) begin
                    mate = ($urandom_range(7) == 0) ? hub : 12'($urandom);
                    cut = ($urandom_range(59) == 0);
                    if ($urandom_range(1)) push_edge(hub, mate, cut);
                    else push_edge(mate, hub, cut);
                end
            end else if (kind <= 7) begin
                base = 12'($urandom);
                len = $urandom_range(30, 10);
                for (int k = 0; k < len; k++) begin
                    push_edge(base + 12'($urandom_range(7)), base + 12'($urandom_range(7)),
                              $urandom_range(99) == 0);
                end
            end else begin
                len = $urandom_range(15, 5);
                for (int k = 0; k < len; k++) begin
                    push_edge(12'($urandom), 12'($urandom), $urandom_range(49) == 0);
                end
            end
            n += len;
            // Close the batch after this sequence now and then
            if ($urandom_range(5) == 0) edge_pending_q[$].last = 1'b1;
        end
    endtask

    // Hold the sender until every queued word is in and every result is out
    task automatic drain_block();
        while (edge_pending_q.size() != 0 || words_accepted != words_offered ||
               color_expect_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Driver: change inputs on the falling edge. Load the next word only once
    // the current one is taken, so valid and payload hold until acceptance.
    always @(negedge aclk) begin : drive
        edge_word_t nxt;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && words_accepted == words_offered) begin
            if (edge_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = edge_pending_q.pop_front();
                s_start_point <= nxt.start_pt;
                s_end_point <= nxt.end_pt;
                s_last_edge <= nxt.last;
                s_valid <= 1'b1;
                words_offered++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: sample both channels on the rising edge. Predict on every
    // accepted edge word, check every accepted color word against the oldest
    // expectation.
    always @(posedge aclk) begin : observe
        edge_word_t    w;
        color_result_t got;
        color_result_t want;
        if (aresetn && s_valid && s_ready) begin
            w.start_pt = s_start_point;
            w.end_pt = s_end_point;
            w.last = s_last_edge;
            color_expect_q.insert(color_expect_q.size(), assign_color(w));
            if (w.last) batches_closed++;
            words_accepted++;
        end
        if (aresetn && m_valid && m_ready) begin
            got.color = m_edge_color;
            got.rank = m_rank_in_color;
            got.no_free = m_no_free_color;
            if (color_expect_q.size() == 0) begin
                note_failure($sformatf("color word with nothing pending: color=%0d rank=%0d flag=%0b",
                                       got.color, got.rank, got.no_free));
            end else begin
                want = color_expect_q.pop_front();
                if (got.color !== want.color || got.rank !== want.rank ||
                    got.no_free !== want.no_free) begin
                    note_failure($sformatf(
                        "result %0d: expected color=%0d rank=%0d flag=%0b, got color=%0d rank=%0d flag=%0b",
                        results_checked, want.color, want.rank, want.no_free,
                        got.color, got.rank, got.no_free));
                end
                if (want.no_free) flagged_seen++;
            end
            results_checked++;
        end
    end

    // Watchdog: end the run when neither channel moves for too long; the
    // limit covers a full clearing pass plus the longest random gaps.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, color_expect_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        clear_color_state();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 88;
                end
                default: begin
                    send_idle_pct = 35;
                    recv_stall_pct = 35;
                end
            endcase
            if (mix == 0) begin
                // Self loops on one point: the bit goes in once, next loop moves up
                push_edge(12'd0, 12'd0, 1'b0);
                push_edge(12'd0, 12'd0, 1'b0);
                push_edge(12'd4095, 12'd4095, 1'b0);
                // Shared endpoints in back-to-back words: masks OR together
                push_edge(12'd0, 12'd4095, 1'b0);
                push_edge(12'd4095, 12'd0, 1'b0);
                push_edge(12'd4095, 12'd4094, 1'b0);
                push_edge(12'd4094, 12'd4095, 1'b0);
                // Triangle on small indices
                push_edge(12'd1, 12'd2, 1'b0);
                push_edge(12'd2, 12'd3, 1'b0);
                push_edge(12'd3, 12'd1, 1'b0);
                // Alternating bit patterns, both directions
                push_edge(12'hAAA, 12'h555, 1'b0);
                push_edge(12'h555, 12'hAAA, 1'b0);
                push_edge(12'hAAA, 12'hAAA, 1'b0);
                // Close the batch, then confirm the stores restart from zero
                push_edge(12'd5, 12'd6, 1'b1);
                push_edge(12'd0, 12'd0, 1'b0);
                push_edge(12'd0, 12'd4095, 1'b0);
                push_edge(12'd4095, 12'd0, 1'b1);
                push_edge(12'd4095, 12'd4095, 1'b0);
            end
            queue_random_edges(ITEMS_PER_MIX);
            drain_block();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d color words from %0d edge words across four idle/stall mixes;",
                 results_checked, words_accepted);
        $display("%0d edges found no free color and %0d batches were closed.",
                 flagged_seen, batches_closed);
        if (failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d failures in total", failures);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/gec_pkg.sv
hw/rtl/greedy_edge_color_assigner_core.sv
tb/greedy_edge_color_assigner_core_tb.sv
